// ===== hw/rtl/ctl_pkg.sv =====
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int COUNT_BITS  = 7;
    localparam int CLASS_BITS  = 3;
    localparam int INDEX_BITS  = 6;
    localparam int FIELD_BITS  = 32;
    localparam int CFG_DATA_BITS = 7;

    typedef enum logic
    {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic
    {
        CFG_CLASS = 1'b0,
        CFG_COUNT = 1'b1
    } cfg_reg_t;

    localparam logic [CLASS_BITS-1:0] CLASS_KERNEL = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLASS_APP    = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLASS_SYS    = 3'd4;

    // controller -> datapath
    typedef struct packed
    {
        logic load_we;
        logic start;
        logic step;
        logic result_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic count_zero;
        logic search_end;
    } dp_sts_t;

endpackage

// ===== hw/rtl/ctl_if.sv =====
`timescale 1ns / 1ps

interface ctl_req_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [ctl_pkg::INDEX_BITS-1:0]   entry_index;
    logic [ctl_pkg::FIELD_BITS-1:0]   entry_key;
    logic [ctl_pkg::FIELD_BITS-1:0]   attr_type;
    logic [ctl_pkg::FIELD_BITS-1:0]   attr_value;

    modport source (output valid, action, entry_index, entry_key, attr_type, attr_value,
                    input ready);
    modport sink   (input valid, action, entry_index, entry_key, attr_type, attr_value,
                    output ready);
endinterface

interface ctl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic                             has_capability;
    logic                             check_passed;
    logic                             get_status;
    logic [ctl_pkg::FIELD_BITS-1:0]   found_type;
    logic [ctl_pkg::FIELD_BITS-1:0]   found_value;

    modport source (output valid, found, has_capability, check_passed, get_status,
                    found_type, found_value, input ready);
    modport sink   (input valid, found, has_capability, check_passed, get_status,
                    found_type, found_value, output ready);
endinterface

// ===== hw/rtl/capability_table_lookup.sv =====
`timescale 1ns / 1ps

// Capability table lookup. Load items write one (key, type, value) slot of the table in the
// cycle they transfer and give no result. A query item binary-searches the first
// entry_count slots (kept sorted by software) and gives one result: found, the stored type
// and value, and the has / check / get answers under the configured process class. The
// table has a single read port with registered data, so the search makes one probe per
// cycle and at most floor(log2(n)) + 1 probes for n valid entries (7 for a full 64-entry
// table). A query holds off new items until its result is loaded into the output
// register, which waits while that register holds an untaken result; a load does not hold
// off the next item. A finished result waits in the output register while the next item
// is taken. Table slots hold whatever was last loaded; no clearing pass is run after reset.
module capability_table_lookup
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    ctl_req_if.sink                            req,
    ctl_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [ctl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    ctl_pkg::dp_cmd_t cmd;
    ctl_pkg::dp_sts_t sts;

    ctl_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ctl_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .entry_index    (req.entry_index),
        .entry_key      (req.entry_key),
        .attr_type      (req.attr_type),
        .attr_value     (req.attr_value),
        .cmd            (cmd),
        .sts            (sts),
        .found          (rsp.found),
        .has_capability (rsp.has_capability),
        .check_passed   (rsp.check_passed),
        .get_status     (rsp.get_status),
        .found_type     (rsp.found_type),
        .found_value    (rsp.found_value)
    );

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_we, cmd.start, cmd.step, cmd.result_load}))
        else $error("datapath commands overlap");

    // a query transfer blocks new items until its result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.action == ctl_pkg::ACT_QUERY) |=> !req.ready)
        else $error("item taken while a query is in flight");

    // a loaded result is presented in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> rsp.valid)
        else $error("result loaded but not presented");

    // stop stepping once the search has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.search_end) |=> !cmd.step)
        else $error("search kept stepping after its end");

endmodule

// ===== hw/rtl/ctl_ctrl.sv =====
`timescale 1ns / 1ps

module ctl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_action,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  ctl_pkg::dp_sts_t  sts,
    output ctl_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_action == ctl_pkg::ACT_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.count_zero ? ST_RESULT : ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (sts.search_end)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/ctl_datapath.sv =====
`timescale 1ns / 1ps

module ctl_datapath
#(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [ctl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [ctl_pkg::INDEX_BITS-1:0]      entry_index,
    input  logic [ctl_pkg::FIELD_BITS-1:0]      entry_key,
    input  logic [ctl_pkg::FIELD_BITS-1:0]      attr_type,
    input  logic [ctl_pkg::FIELD_BITS-1:0]      attr_value,
    input  ctl_pkg::dp_cmd_t                    cmd,
    output ctl_pkg::dp_sts_t                    sts,
    output logic                                found,
    output logic                                has_capability,
    output logic                                check_passed,
    output logic                                get_status,
    output logic [ctl_pkg::FIELD_BITS-1:0]      found_type,
    output logic [ctl_pkg::FIELD_BITS-1:0]      found_value
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int KW = (KEY_BITS < ctl_pkg::FIELD_BITS) ? KEY_BITS : ctl_pkg::FIELD_BITS;
    localparam int FW = ctl_pkg::FIELD_BITS;
    localparam int CW = ctl_pkg::COUNT_BITS;
    localparam int SW = CW + 1;
    localparam int WW = KW + 2 * FW;

    logic [ctl_pkg::CLASS_BITS-1:0] class_reg;
    logic [CW-1:0]                  count_reg;

    logic [WW-1:0]        mem [TABLE_DEPTH];
    logic [WW-1:0]        rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;

    logic signed [SW-1:0] left_reg, right_reg;
    logic [CW-1:0]        mid_reg;
    logic [KW-1:0]        key_q_reg;
    logic [FW-1:0]        type_q_reg, value_q_reg;
    logic                 hit_reg;
    logic [FW-1:0]        hit_type_reg, hit_value_reg;

    logic                 found_reg, has_reg, check_reg, get_reg;
    logic [FW-1:0]        found_type_reg, found_value_reg;

    logic [CW-1:0]        n;
    logic [CW-1:0]        mid0;
    logic [KW-1:0]        rd_key;
    logic [FW-1:0]        rd_type, rd_value;
    logic                 gt, lt, eq;
    logic signed [SW-1:0] mid_s, left_next, right_next, span, mid_sum;
    logic [CW-1:0]        mid_next;
    logic                 kernel, allowed, match;

    // effective count, saturated to the table size
    assign n    = (32'(count_reg) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : count_reg;
    assign mid0 = CW'((n - CW'(1)) >> 1);

    assign rd_key   = rdata_reg[WW-1 -: KW];
    assign rd_type  = rdata_reg[2*FW-1 -: FW];
    assign rd_value = rdata_reg[FW-1:0];

    assign gt = key_q_reg > rd_key;
    assign lt = key_q_reg < rd_key;
    assign eq = !gt && !lt;

    assign mid_s      = signed'({1'b0, mid_reg});
    assign left_next  = gt ? mid_s + SW'(1) : left_reg;
    assign right_next = lt ? mid_s - SW'(1) : right_reg;
    assign span       = right_next - left_next;
    assign mid_sum    = left_next + (span >>> 1);
    assign mid_next   = mid_sum[CW-1:0];

    assign sts.count_zero = (n == '0);
    assign sts.search_end = eq || (left_next > right_next);

    assign rd_addr = cmd.start ? AW'(mid0) : AW'(mid_next);
    assign wr_en   = cmd.load_we && (32'(entry_index) < TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(entry_index)] <= {entry_key[KW-1:0], attr_type, attr_value};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ctl_pkg::CFG_CLASS: class_reg <= cfg_data[ctl_pkg::CLASS_BITS-1:0];
                ctl_pkg::CFG_COUNT: count_reg <= cfg_data[CW-1:0];
                default:            class_reg <= class_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            left_reg    <= '0;
            right_reg   <= signed'({1'b0, n}) - SW'(1);
            mid_reg     <= mid0;
            key_q_reg   <= entry_key[KW-1:0];
            type_q_reg  <= attr_type;
            value_q_reg <= attr_value;
            hit_reg     <= 1'b0;
        end
        else if (cmd.step)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            mid_reg   <= mid_next;
            if (eq)
            begin
                hit_reg       <= 1'b1;
                hit_type_reg  <= rd_type;
                hit_value_reg <= rd_value;
            end
        end
    end

    assign kernel  = (class_reg == ctl_pkg::CLASS_KERNEL);
    assign allowed = (class_reg == ctl_pkg::CLASS_APP) || (class_reg == ctl_pkg::CLASS_SYS);
    assign match   = (hit_type_reg == type_q_reg) && (hit_value_reg == value_q_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            found_reg       <= hit_reg;
            has_reg         <= kernel || (allowed && hit_reg);
            check_reg       <= kernel || (allowed && hit_reg && match);
            get_reg         <= !(allowed && hit_reg);
            found_type_reg  <= hit_reg ? hit_type_reg : '0;
            found_value_reg <= hit_reg ? hit_value_reg : '0;
        end
    end

    assign found          = found_reg;
    assign has_capability = has_reg;
    assign check_passed   = check_reg;
    assign get_status     = get_reg;
    assign found_type     = found_type_reg;
    assign found_value    = found_value_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int                             SLOTS          = 64;
    localparam int                             SEARCH_SETTLE  = 12;
    localparam int                             STALL_LIMIT    = 3000;
    localparam int                             HOLD_CYCLES    = 300;
    localparam logic [ctl_pkg::CLASS_BITS-1:0] CLASS_UNKNOWN  = 3'd0;
    localparam logic [ctl_pkg::CLASS_BITS-1:0] CLASS_UNSET    = 3'd1;
    localparam logic [ctl_pkg::CLASS_BITS-1:0] CLASS_SPARE_LO = 3'd5;
    localparam logic [ctl_pkg::CLASS_BITS-1:0] CLASS_SPARE_HI = 3'd7;

    typedef struct packed
    {
        ctl_pkg::action_t                 action;
        logic [ctl_pkg::INDEX_BITS-1:0]   entry_index;
        logic [ctl_pkg::FIELD_BITS-1:0]   entry_key;
        logic [ctl_pkg::FIELD_BITS-1:0]   attr_type;
        logic [ctl_pkg::FIELD_BITS-1:0]   attr_value;
    } cap_item_t;

    typedef struct packed
    {
        logic                             found;
        logic                             has_capability;
        logic                             check_passed;
        logic                             get_status;
        logic [ctl_pkg::FIELD_BITS-1:0]   found_type;
        logic [ctl_pkg::FIELD_BITS-1:0]   found_value;
    } cap_result_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    ctl_pkg::cfg_reg_t                    cfg_index;
    logic [ctl_pkg::CFG_DATA_BITS-1:0]    cfg_data;

    ctl_req_if req_ch();
    ctl_rsp_if rsp_ch();

    capability_table_lookup dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the table and the policy registers
    logic [ctl_pkg::FIELD_BITS-1:0]       tbl_key   [SLOTS];
    logic [ctl_pkg::FIELD_BITS-1:0]       tbl_type  [SLOTS];
    logic [ctl_pkg::FIELD_BITS-1:0]       tbl_value [SLOTS];
    logic [ctl_pkg::CLASS_BITS-1:0]       cur_class;
    logic [ctl_pkg::COUNT_BITS-1:0]       cur_count;

    cap_result_t                 pending_lookups[$];
    int                          fail_count;
    int                          quiet_cycles;
    bit                          idle_on;
    bit                          hold_go;
    int                          hold_left;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic cap_result_t predict_lookup(cap_item_t it);
        int          n;
        int          lo;
        int          hi;
        int          mid;
        int          slot;
        logic        kernel;
        logic        allowed;
        cap_result_t r;
        n = (int'(cur_count) > SLOTS) ? SLOTS : int'(cur_count);
        lo = 0;
        hi = n - 1;
        slot = -1;
        while (lo <= hi && slot < 0)
        begin
            mid = lo + (hi - lo) / 2;
            if (it.entry_key > tbl_key[mid])
                lo = mid + 1;
            else if (it.entry_key < tbl_key[mid])
                hi = mid - 1;
            else
                slot = mid;
        end
        kernel  = (cur_class == ctl_pkg::CLASS_KERNEL);
        allowed = (cur_class == ctl_pkg::CLASS_APP) || (cur_class == ctl_pkg::CLASS_SYS);
        r.found          = (slot >= 0);
        r.found_type     = r.found ? tbl_type[slot]  : '0;
        r.found_value    = r.found ? tbl_value[slot] : '0;
        r.has_capability = kernel || (allowed && r.found);
        r.check_passed   = kernel || (allowed && r.found && r.found_type == it.attr_type
                                      && r.found_value == it.attr_value);
        r.get_status     = !(allowed && r.found);
        return r;
    endfunction

    // random item shaped around the current table contents
    function automatic cap_item_t make_lookup_item();
        int              n;
        int              s;
        int              pick;
        longint unsigned lo_k;
        longint unsigned hi_k;
        cap_item_t       it;
        n = (int'(cur_count) > SLOTS) ? SLOTS : int'(cur_count);
        pick = $urandom_range(99);
        it.action      = ctl_pkg::ACT_QUERY;
        it.entry_index = ctl_pkg::INDEX_BITS'($urandom);
        it.entry_key   = $urandom;
        it.attr_type   = $urandom;
        it.attr_value  = $urandom;
        if (pick < 55 && n > 0)
        begin
            s = $urandom_range(n - 1);
            it.entry_key = tbl_key[s];
            if ($urandom_range(1))
            begin
                it.attr_type  = tbl_type[s];
                it.attr_value = tbl_value[s];
            end
            else if ($urandom_range(1))
            begin
                it.attr_type  = tbl_type[s];
                it.attr_value = tbl_value[s] ^ (32'd1 << $urandom_range(31));
            end
            else
            begin
                it.attr_type  = tbl_type[s] ^ (32'd1 << $urandom_range(31));
                it.attr_value = tbl_value[s];
            end
        end
        else if (pick < 70)
        begin
            if (n > 0)
                it.entry_key = tbl_key[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
        end
        else if (pick < 90)
        begin
            // rewrite a slot, keeping the key order where the neighbors allow it
            s = $urandom_range(SLOTS - 1);
            it.action      = ctl_pkg::ACT_LOAD;
            it.entry_index = ctl_pkg::INDEX_BITS'(s);
            lo_k = (s == 0) ? 64'd0 : 64'(tbl_key[s - 1]);
            hi_k = (s == SLOTS - 1) ? 64'hFFFF_FFFF : 64'(tbl_key[s + 1]);
            if (lo_k <= hi_k)
                it.entry_key = ctl_pkg::FIELD_BITS'(lo_k
                               + ({32'd0, $urandom} % (hi_k - lo_k + 1)));
            else
                it.entry_key = tbl_key[s];
        end
        else
        begin
            it.action = ctl_pkg::ACT_LOAD;
        end
        return it;
    endfunction

    task automatic send_item(input cap_item_t it);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= it.action;
        req_ch.entry_index <= it.entry_index;
        req_ch.entry_key   <= it.entry_key;
        req_ch.attr_type   <= it.attr_type;
        req_ch.attr_value  <= it.attr_value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (it.action == ctl_pkg::ACT_LOAD)
        begin
            tbl_key[it.entry_index]   = it.entry_key;
            tbl_type[it.entry_index]  = it.attr_type;
            tbl_value[it.entry_index] = it.attr_value;
        end
        else
        begin
            pending_lookups.push_back(predict_lookup(it));
        end
    endtask

    task automatic send_load(input int idx, input logic [31:0] k, input logic [31:0] t,
                             input logic [31:0] v);
        send_item('{ctl_pkg::ACT_LOAD, idx[ctl_pkg::INDEX_BITS-1:0], k, t, v});
    endtask

    task automatic send_query(input logic [31:0] k, input logic [31:0] t,
                              input logic [31:0] v);
        send_item('{ctl_pkg::ACT_QUERY, ctl_pkg::INDEX_BITS'($urandom), k, t, v});
    endtask

    // drop valid and hold until the block has nothing left in flight
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SEARCH_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input ctl_pkg::cfg_reg_t r,
                             input logic [ctl_pkg::CFG_DATA_BITS-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        if (r == ctl_pkg::CFG_CLASS)
            cur_class = d[ctl_pkg::CLASS_BITS-1:0];
        else
            cur_count = d[ctl_pkg::COUNT_BITS-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_policy(input logic [ctl_pkg::CLASS_BITS-1:0] cls, input int count);
        wait_drained();
        write_reg(ctl_pkg::CFG_CLASS, ctl_pkg::CFG_DATA_BITS'(cls));
        write_reg(ctl_pkg::CFG_COUNT, ctl_pkg::CFG_DATA_BITS'(count));
    endtask

    task automatic load_sorted_table();
        bit [31:0] keys[$];
        for (int i = 0; i < SLOTS; i++)
            keys.push_back($urandom);
        if ($urandom_range(1))
        begin
            keys[0] = 32'd0;
            keys[1] = 32'hFFFF_FFFF;
        end
        keys.sort();
        for (int i = 0; i < SLOTS; i++)
            send_load(i, keys[i], $urandom, $urandom);
    endtask

    task automatic test_empty_after_reset();
        send_query(32'd0, 32'd0, 32'd0);
    endtask

    task automatic test_small_table_policy();
        send_load(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_load(1, 32'h0000_0005, 32'h0000_0011, 32'h0000_0022);
        send_load(2, 32'h0000_0064, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_load(3, 32'h0000_03E8, 32'h1234_5678, 32'h8765_4321);
        send_load(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_load(5, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_load(6, 32'hFFFF_FFFE, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        send_load(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(SLOTS - 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F);

        set_policy(ctl_pkg::CLASS_APP, 8);
        send_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_query(32'h0000_0006, 32'h0000_0000, 32'h0000_0000);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);

        set_policy(ctl_pkg::CLASS_SYS, 8);
        send_query(32'h0000_03E8, 32'h1234_5678, 32'h8765_4321);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // kernel passes has/check even on a miss, and still returns the entry on a hit
        set_policy(ctl_pkg::CLASS_KERNEL, 8);
        send_query(32'h0000_0065, 32'h0000_0000, 32'h0000_0000);
        send_query(32'h0000_0005, 32'h0000_0011, 32'h0000_0022);

        set_policy(CLASS_UNSET, 8);
        send_query(32'h0000_0005, 32'h0000_0011, 32'h0000_0022);

        // found is still reported under a failing class
        set_policy(CLASS_SPARE_LO, 8);
        send_query(32'h0000_0064, 32'hA5A5_A5A5, 32'h5A5A_5A5A);

        set_policy(ctl_pkg::CLASS_KERNEL, 0);
        send_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

        // a key past the valid count must miss
        set_policy(ctl_pkg::CLASS_APP, 3);
        send_query(32'h0000_03E8, 32'h1234_5678, 32'h8765_4321);
        send_query(32'h0000_0064, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    endtask

    task automatic test_sorted_table_lookups();
        int                             count_plan[8];
        logic [ctl_pkg::CLASS_BITS-1:0] cls;
        count_plan = '{64, 2, 127, 64, 127, 0, 1, 63};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 4 == 0)
                load_sorted_table();
            cls = ph[ctl_pkg::CLASS_BITS-1:0];
            set_policy(cls, count_plan[ph]);
            for (int i = 0; i < 80; i++)
                send_item(make_lookup_item());
        end
        set_policy(CLASS_SPARE_HI, 64);
        for (int i = 0; i < 20; i++)
            send_item(make_lookup_item());
    endtask

    task automatic test_back_to_back();
        load_sorted_table();
        idle_on = 1'b0;
        set_policy(ctl_pkg::CLASS_APP, $urandom_range(1, SLOTS));
        for (int i = 0; i < 60; i++)
            send_item(make_lookup_item());
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        set_policy(ctl_pkg::CLASS_SYS, SLOTS);
        hold_go = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(make_lookup_item());
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_item(make_lookup_item());
    endtask

    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 28);
        end
    end

    always @(posedge clk)
    begin
        cap_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected lookup result at %0t", $realtime);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (rsp_ch.found !== want.found
                    || rsp_ch.has_capability !== want.has_capability
                    || rsp_ch.check_passed !== want.check_passed
                    || rsp_ch.get_status !== want.get_status
                    || rsp_ch.found_type !== want.found_type
                    || rsp_ch.found_value !== want.found_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("lookup mismatch at %0t: exp f=%b h=%b c=%b g=%b t=%h v=%h,",
                               $realtime, want.found, want.has_capability,
                               want.check_passed, want.get_status, want.found_type,
                               want.found_value);
                        $display(" got f=%b h=%b c=%b g=%b t=%h v=%h",
                                 rsp_ch.found, rsp_ch.has_capability,
                                 rsp_ch.check_passed, rsp_ch.get_status,
                                 rsp_ch.found_type, rsp_ch.found_value);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = ctl_pkg::CFG_CLASS;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ctl_pkg::ACT_LOAD;
        req_ch.entry_index = '0;
        req_ch.entry_key   = '0;
        req_ch.attr_type   = '0;
        req_ch.attr_value  = '0;
        rsp_ch.ready       = 1'b0;
        cur_class          = CLASS_UNKNOWN;
        cur_count          = '0;
        fail_count         = 0;
        quiet_cycles       = 0;
        idle_on            = 1'b1;
        hold_go            = 1'b0;
        hold_left          = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_key[i]   = '0;
            tbl_type[i]  = '0;
            tbl_value[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_after_reset();
        test_small_table_policy();
        test_sorted_table_lookups();
        test_back_to_back();
        test_backpressure();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ctl_pkg.sv
hw/rtl/ctl_if.sv
hw/rtl/ctl_ctrl.sv
hw/rtl/ctl_datapath.sv
hw/rtl/capability_table_lookup.sv
sim/tb_top.sv
